// ----- design/rc6d_pkg.sv -----
package rc6d_pkg;

  // Fixed field widths
  localparam int unsigned UNIT_W     = 14;
  localparam int unsigned HDR_W      = 15;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned EXP_W      = 15;  // expected duration, covers 2 * unit
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned ADDR_BITS  = 8;
  localparam int unsigned CMD_BITS   = 8;
  localparam int unsigned MODE_BITS  = 3;
  localparam int unsigned WORD_W     = MODE_BITS + 1 + ADDR_BITS + CMD_BITS;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned STATUS_W   = 2;

  // Frame positions
  localparam logic [POS_W-1:0] POS_LEADER  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_START   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TOGGLE  = POS_W'(5);
  localparam logic [POS_W-1:0] POS_END     = POS_W'(6 + ADDR_BITS + CMD_BITS);
  localparam logic [POS_W-1:0] MIN_SYMBOLS = POS_W'(20);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TOL    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HDR_TOL    = CFG_IDX_W'(4);

  // Register reset values
  localparam logic [UNIT_W-1:0] UNIT_RST       = UNIT_W'(444);
  localparam logic [HDR_W-1:0]  HDR_MARK_RST   = HDR_W'(2666);
  localparam logic [HDR_W-1:0]  HDR_SPACE_RST  = HDR_W'(889);
  localparam logic [PCT_W-1:0]  BIT_TOL_RST    = PCT_W'(30);
  localparam logic [PCT_W-1:0]  HDR_TOL_RST    = PCT_W'(25);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_FAIL  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_SHORT = STATUS_W'(2);

  typedef struct packed {
    logic [UNIT_W-1:0] unit_dur;
    logic [HDR_W-1:0]  hdr_mark;
    logic [HDR_W-1:0]  hdr_space;
    logic [PCT_W-1:0]  bit_tol;
    logic [PCT_W-1:0]  hdr_tol;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [MODE_BITS-1:0] mode_bits;
    logic                 toggle;
    logic [ADDR_BITS-1:0] address;
    logic [CMD_BITS-1:0]  command_code;
    logic [WORD_W-1:0]    data_word;
  } result_t;

endpackage

// ----- design/rc6_mode0_frame_decoder_top.sv -----
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    first_level_i, first_duration_i,
//                                                 second_level_i, second_duration_i,
//                                                 buffer_last_i
// out       source     out_valid_o / out_stall_i  status_o, mode_bits_o, toggle_o,
//                                                 address_o, command_code_o, data_word_o
// cfg       sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle while the input is not stalled: an accepted item is decoded
// straight out of the input register, and its result (only for the buffer's last
// item) lands in the output register when the item advances.
// The leader and bit window checks are one pass of logic between the two registers.
// Reset clears the frame state and loads the default timing registers.
// A stalled output holds its result; items without a result keep flowing, and
// the input stalls only when a last item waits on a full, stalled output.
module rc6_mode0_frame_decoder_top import rc6d_pkg::*; #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     first_level_i,
  input  logic [DURATION_BITS-1:0] first_duration_i,
  input  logic                     second_level_i,
  input  logic [DURATION_BITS-1:0] second_duration_i,
  input  logic                     buffer_last_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [MODE_BITS-1:0]     mode_bits_o,
  output logic                     toggle_o,
  output logic [ADDR_BITS-1:0]     address_o,
  output logic [CMD_BITS-1:0]      command_code_o,
  output logic [WORD_W-1:0]        data_word_o,

  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  cfg_t cfg;

  // Input register
  logic                     s1_valid_q, s1_valid_d;
  logic                     s1_l0_q, s1_l1_q, s1_last_q;
  logic [DURATION_BITS-1:0] s1_d0_q, s1_d1_q;

  // Output register
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t result;

  logic in_accept, s1_adv, out_free, out_load;

  // Registers are always writable; the user must write them only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  rc6d_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the held item unless it carries a result and the output is blocked.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign out_load   = s1_adv && s1_last_q;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  rc6d_symbol_dec #(.DURATION_BITS(DURATION_BITS)) u_dec (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .fire_i            (s1_adv),
    .first_level_i     (s1_l0_q),
    .first_duration_i  (s1_d0_q),
    .second_level_i    (s1_l1_q),
    .second_duration_i (s1_d1_q),
    .buffer_last_i     (s1_last_q),
    .result_o          (result)
  );

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_l0_q   <= first_level_i;
      s1_d0_q   <= first_duration_i;
      s1_l1_q   <= second_level_i;
      s1_d1_q   <= second_duration_i;
      s1_last_q <= buffer_last_i;
    end
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign mode_bits_o    = out_q.mode_bits;
  assign toggle_o       = out_q.toggle;
  assign address_o      = out_q.address;
  assign command_code_o = out_q.command_code;
  assign data_word_o    = out_q.data_word;

  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != STATUS_OK |-> out_q.data_word == '0)
    else $error("non-ok result carries data");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q)
    else $error("input stalled without a blocked result");

  a_out_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last item");

endmodule

// ----- design/rc6d_cfg_regs.sv -----
module rc6d_cfg_regs import rc6d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_dur  <= UNIT_RST;
      cfg_q.hdr_mark  <= HDR_MARK_RST;
      cfg_q.hdr_space <= HDR_SPACE_RST;
      cfg_q.bit_tol   <= BIT_TOL_RST;
      cfg_q.hdr_tol   <= HDR_TOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_UNIT:      cfg_q.unit_dur  <= cfg_data_i[UNIT_W-1:0];
        REG_HDR_MARK:  cfg_q.hdr_mark  <= cfg_data_i[HDR_W-1:0];
        REG_HDR_SPACE: cfg_q.hdr_space <= cfg_data_i[HDR_W-1:0];
        REG_BIT_TOL:   cfg_q.bit_tol   <= cfg_data_i[PCT_W-1:0];
        REG_HDR_TOL:   cfg_q.hdr_tol   <= cfg_data_i[PCT_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/rc6d_tol_chk.sv -----
module rc6d_tol_chk import rc6d_pkg::*; #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic [DURATION_BITS-1:0] dur_i,
  input  logic [EXP_W-1:0]         exp_i,
  input  logic [PCT_W-1:0]         pct_i,
  output logic                     match_o
);

  localparam int unsigned CW = (DURATION_BITS > EXP_W) ? DURATION_BITS : EXP_W;
  localparam int unsigned PW = CW + 7;

  logic [CW-1:0] dur_ext;
  logic [CW-1:0] exp_ext;
  logic [CW-1:0] diff;
  logic [PW-1:0] lhs;
  logic [PW-1:0] rhs;

  // |d - e| * 100 <= e * pct
  assign dur_ext = CW'(dur_i);
  assign exp_ext = CW'(exp_i);
  assign diff    = (dur_ext > exp_ext) ? (dur_ext - exp_ext) : (exp_ext - dur_ext);
  assign lhs     = PW'(diff) * PW'(100);
  assign rhs     = PW'(exp_i) * PW'(pct_i);
  assign match_o = (lhs <= rhs);

endmodule

// ----- design/rc6d_symbol_dec.sv -----
module rc6d_symbol_dec import rc6d_pkg::*; #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     fire_i,
  input  logic                     first_level_i,
  input  logic [DURATION_BITS-1:0] first_duration_i,
  input  logic                     second_level_i,
  input  logic [DURATION_BITS-1:0] second_duration_i,
  input  logic                     buffer_last_i,
  output result_t                  result_o
);

  logic [POS_W-1:0]  pos_q, pos_d, pos_upd;
  logic [POS_W-1:0]  cnt_q, cnt_d, cnt_upd;
  logic              failed_q, failed_d, failed_upd;
  logic [WORD_W-1:0] shift_q, shift_d, shift_upd;

  logic [EXP_W-1:0] exp0, exp1;
  logic [PCT_W-1:0] pct;
  logic             ok0, ok1;
  logic             active, fail_now;

  always_comb begin
    if (pos_q == POS_LEADER) begin
      exp0 = EXP_W'(cfg_i.hdr_mark);
      exp1 = EXP_W'(cfg_i.hdr_space);
      pct  = cfg_i.hdr_tol;
    end else if (pos_q == POS_TOGGLE) begin
      exp0 = {cfg_i.unit_dur, 1'b0};
      exp1 = {cfg_i.unit_dur, 1'b0};
      pct  = cfg_i.bit_tol;
    end else begin
      exp0 = EXP_W'(cfg_i.unit_dur);
      exp1 = EXP_W'(cfg_i.unit_dur);
      pct  = cfg_i.bit_tol;
    end
  end

  rc6d_tol_chk #(.DURATION_BITS(DURATION_BITS)) u_chk_first (
    .dur_i   (first_duration_i),
    .exp_i   (exp0),
    .pct_i   (pct),
    .match_o (ok0)
  );

  rc6d_tol_chk #(.DURATION_BITS(DURATION_BITS)) u_chk_second (
    .dur_i   (second_duration_i),
    .exp_i   (exp1),
    .pct_i   (pct),
    .match_o (ok1)
  );

  always_comb begin
    active = !failed_q && (pos_q < POS_END);
    if (pos_q == POS_LEADER) begin
      fail_now = !(first_level_i && !second_level_i && ok0 && ok1);
    end else begin
      fail_now = !(ok0 && ok1) || ((pos_q == POS_START) && !first_level_i);
    end

    cnt_upd    = (cnt_q < MIN_SYMBOLS) ? cnt_q + POS_W'(1) : cnt_q;
    failed_upd = failed_q || (active && fail_now);
    pos_upd    = (active && !fail_now) ? pos_q + POS_W'(1) : pos_q;
    shift_upd  = shift_q;
    if (active && !fail_now && (pos_q != POS_LEADER) && (pos_q != POS_START)) begin
      shift_upd = {shift_q[WORD_W-2:0], first_level_i};
    end

    // Result as seen after this symbol
    result_o = '0;
    if (cnt_upd < MIN_SYMBOLS) begin
      result_o.status = STATUS_SHORT;
    end else if (failed_upd || (pos_upd < POS_END)) begin
      result_o.status = STATUS_FAIL;
    end else begin
      result_o.status       = STATUS_OK;
      result_o.mode_bits    = shift_upd[WORD_W-1 -: MODE_BITS];
      result_o.toggle       = shift_upd[ADDR_BITS + CMD_BITS];
      result_o.address      = shift_upd[CMD_BITS +: ADDR_BITS];
      result_o.command_code = shift_upd[CMD_BITS-1:0];
      result_o.data_word    = shift_upd;
    end

    // Hold when idle, rearm after the buffer's last symbol
    if (!fire_i) begin
      pos_d = pos_q; cnt_d = cnt_q; failed_d = failed_q; shift_d = shift_q;
    end else if (buffer_last_i) begin
      pos_d = '0; cnt_d = '0; failed_d = 1'b0; shift_d = '0;
    end else begin
      pos_d = pos_upd; cnt_d = cnt_upd; failed_d = failed_upd; shift_d = shift_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cnt_q    <= '0;
      failed_q <= 1'b0;
      shift_q  <= '0;
    end else begin
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      failed_q <= failed_d;
      shift_q  <= shift_d;
    end
  end

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_END) else $error("position past frame end");

  a_cnt_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MIN_SYMBOLS) else $error("symbol count not saturated");

  a_rearm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && buffer_last_i |=> pos_q == '0 && cnt_q == '0 && !failed_q)
    else $error("decoder not rearmed after last symbol");

  a_fail_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q && !(fire_i && buffer_last_i) |=> failed_q && $stable(pos_q))
    else $error("failed buffer advanced");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

// Testbench for the mode-0 frame decoder.
// Drives whole symbol buffers (leader, start bit, mode, toggle, address and
// command bits) through the valid/stall input, predicts each frame result with
// a local decoder model or the directed plan, and checks each result field by field in order.
module tb_top;
  import rc6d_pkg::*;

  localparam int unsigned DUR_W    = 15;
  localparam int unsigned DUR_MAX  = (1 << DUR_W) - 1;
  localparam int unsigned FRAME_SYMBOLS = 22;  // leader plus 21 bit symbols
  localparam int unsigned PHASE_ITEMS   = 175;
  localparam int unsigned PRINT_CAP     = 200;

  // Index past the register list: a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

  typedef struct packed {
    logic           first_level;
    logic [DUR_W-1:0] first_dur;
    logic           second_level;
    logic [DUR_W-1:0] second_dur;
    logic           last;
  } symbol_t;

  // Ways to spoil (or stress) one symbol of a buffer.
  typedef enum logic [2:0] {
    FLAW_NONE,
    FLAW_LEVEL,        // leader level swapped, start bit low, or data second level wrong
    FLAW_FIRST_HALF,   // first half outside the window
    FLAW_SECOND_HALF,  // second half outside the window
    FLAW_NOISE,        // fully random symbol
    FLAW_EDGE_IN,      // both halves right on the window edges
    FLAW_EDGE_OUT      // first half one tick past the window edge
  } flaw_e;

  typedef struct packed {
    logic [5:0]          n_symbols;
    logic [19:0]         word;
    logic [4:0]          flaw_pos;
    flaw_e               flaw;
    logic                typed;
    logic [STATUS_W-1:0] exp_status;
  } directed_row_t;

  // Directed buffers under the reset timing. Rows with typed set carry the
  // result read straight off the frame: status plus the word when it is ok.
  localparam directed_row_t DIRECTED_PLAN [21] = '{
    '{6'd1,  20'h00000, 5'd0,  FLAW_NONE,        1'b1, STATUS_SHORT},
    '{6'd22, 20'h00000, 5'd0,  FLAW_NONE,        1'b1, STATUS_OK},
    '{6'd22, 20'hFFFFF, 5'd0,  FLAW_NONE,        1'b1, STATUS_OK},
    '{6'd22, 20'h5A5C3, 5'd0,  FLAW_NONE,        1'b1, STATUS_OK},
    '{6'd19, 20'h5A5C3, 5'd0,  FLAW_NONE,        1'b1, STATUS_SHORT},
    '{6'd20, 20'hFFFFF, 5'd0,  FLAW_NONE,        1'b1, STATUS_FAIL},
    '{6'd21, 20'hFFFFF, 5'd0,  FLAW_NONE,        1'b1, STATUS_FAIL},
    '{6'd22, 20'h12345, 5'd0,  FLAW_LEVEL,       1'b1, STATUS_FAIL},
    '{6'd22, 20'h12345, 5'd0,  FLAW_FIRST_HALF,  1'b1, STATUS_FAIL},
    '{6'd22, 20'h12345, 5'd0,  FLAW_SECOND_HALF, 1'b1, STATUS_FAIL},
    '{6'd22, 20'hFFFFF, 5'd1,  FLAW_LEVEL,       1'b1, STATUS_FAIL},
    '{6'd22, 20'h0F0F0, 5'd5,  FLAW_FIRST_HALF,  1'b1, STATUS_FAIL},
    '{6'd22, 20'h0F0F0, 5'd21, FLAW_SECOND_HALF, 1'b1, STATUS_FAIL},
    '{6'd22, 20'h3C3C3, 5'd9,  FLAW_LEVEL,       1'b1, STATUS_OK},
    '{6'd26, 20'hC0FFE, 5'd0,  FLAW_NONE,        1'b1, STATUS_OK},
    '{6'd30, 20'h00001, 5'd3,  FLAW_NOISE,       1'b0, STATUS_OK},
    '{6'd22, 20'h80000, 5'd12, FLAW_NOISE,       1'b0, STATUS_OK},
    '{6'd22, 20'h7E7E7, 5'd0,  FLAW_EDGE_IN,     1'b1, STATUS_OK},
    '{6'd22, 20'h7E7E7, 5'd5,  FLAW_EDGE_IN,     1'b1, STATUS_OK},
    '{6'd22, 20'h7E7E7, 5'd7,  FLAW_EDGE_OUT,    1'b1, STATUS_FAIL},
    '{6'd22, 20'h7E7E7, 5'd0,  FLAW_EDGE_OUT,    1'b1, STATUS_FAIL}
  };

  // DUT-facing signals; the driven inputs are all known from time zero.
  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_stall_o;
  logic                  first_level_i     = 1'b0;
  logic [DUR_W-1:0]      first_duration_i  = '0;
  logic                  second_level_i    = 1'b0;
  logic [DUR_W-1:0]      second_duration_i = '0;
  logic                  buffer_last_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i       = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [MODE_BITS-1:0]  mode_bits_o;
  logic                  toggle_o;
  logic [ADDR_BITS-1:0]  address_o;
  logic [CMD_BITS-1:0]   command_code_o;
  logic [WORD_W-1:0]     data_word_o;
  logic                  cfg_valid_i       = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;

  // Local copy of the timing registers and of the frame state.
  cfg_t            timing;
  logic [POS_W-1:0] frame_pos;
  logic [POS_W-1:0] symbols_seen;
  logic            frame_failed;
  logic [19:0]     frame_bits;

  result_t     expected_frames [$];
  int unsigned mismatch_count   = 0;
  int unsigned symbols_decoded  = 0;  // symbols sent at decoding positions
  int unsigned send_idle_pct    = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned stall_hold_cycles = 0;

  rc6_mode0_frame_decoder_top #(
    .DURATION_BITS(DUR_W)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_level_i    (first_level_i),
    .first_duration_i (first_duration_i),
    .second_level_i   (second_level_i),
    .second_duration_i(second_duration_i),
    .buffer_last_i    (buffer_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .mode_bits_o      (mode_bits_o),
    .toggle_o         (toggle_o),
    .address_o        (address_o),
    .command_code_o   (command_code_o),
    .data_word_o      (data_word_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame decoder model
  // ---------------------------------------------------------------------------

  // Duration d matches e when |d - e| * 100 <= e * pct.
  function automatic bit in_window(int unsigned d, int unsigned e, int unsigned pct);
    int unsigned diff;
    diff = (d > e) ? d - e : e - d;
    return (longint'(diff) * 100) <= (longint'(e) * pct);
  endfunction

  // Split the 20-bit frame word into result fields; a non-ok status zeros them.
  function automatic result_t frame_result(logic [STATUS_W-1:0] st, logic [19:0] word);
    result_t     r;
    logic [19:0] w;
    w              = (st == STATUS_OK) ? word : '0;
    r.status       = st;
    r.mode_bits    = w[19:17];
    r.toggle       = w[16];
    r.address      = w[15:8];
    r.command_code = w[7:0];
    r.data_word    = w;
    return r;
  endfunction

  function automatic void rearm_frame();
    frame_pos    = POS_LEADER;
    symbols_seen = '0;
    frame_failed = 1'b0;
    frame_bits   = '0;
  endfunction

  // Advance the frame state by one symbol; return 1 with the frame result
  // when the symbol closes the buffer.
  function automatic bit decode_symbol(input symbol_t s, output result_t r);
    int unsigned         e;
    logic [STATUS_W-1:0] st;
    r = '0;
    if (symbols_seen < MIN_SYMBOLS) symbols_seen++;
    if (!frame_failed && frame_pos < POS_END) begin
      if (frame_pos == POS_LEADER) begin
        if (s.first_level != 1'b1 || s.second_level != 1'b0 ||
            !in_window(s.first_dur, timing.hdr_mark, timing.hdr_tol) ||
            !in_window(s.second_dur, timing.hdr_space, timing.hdr_tol))
          frame_failed = 1'b1;
      end else begin
        // The toggle bit runs at twice the unit time.
        e = (frame_pos == POS_TOGGLE) ? 2 * timing.unit_dur : timing.unit_dur;
        if (!in_window(s.first_dur, e, timing.bit_tol) ||
            !in_window(s.second_dur, e, timing.bit_tol))
          frame_failed = 1'b1;
        else if (frame_pos == POS_START) begin
          if (s.first_level != 1'b1) frame_failed = 1'b1;
        end else
          frame_bits = {frame_bits[18:0], s.first_level};
      end
      if (!frame_failed) frame_pos++;
    end
    if (!s.last) return 1'b0;
    if (symbols_seen < MIN_SYMBOLS) st = STATUS_SHORT;
    else if (frame_failed || frame_pos < POS_END) st = STATUS_FAIL;
    else st = STATUS_OK;
    r = frame_result(st, frame_bits);
    rearm_frame();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Symbol construction
  // ---------------------------------------------------------------------------

  function automatic logic [DUR_W-1:0] clamp_dur(longint v);
    if (v < 0) return '0;
    if (v > DUR_MAX) return DUR_W'(DUR_MAX);
    return DUR_W'(v);
  endfunction

  // Pick a duration inside the window, now and then right on its edge.
  function automatic logic [DUR_W-1:0] near_dur(int unsigned e, int unsigned pct);
    int unsigned slack;
    int unsigned off;
    slack = e * pct / 100;
    off   = ($urandom_range(7) == 0) ? slack : $urandom_range(slack);
    return $urandom_range(1) ? clamp_dur(longint'(e) + off) : clamp_dur(longint'(e) - off);
  endfunction

  // Pick a duration outside the window (clamping may pull it back in).
  function automatic logic [DUR_W-1:0] far_dur(int unsigned e, int unsigned pct);
    int unsigned off;
    off = e * pct / 100 + 1 + $urandom_range(e / 2 + 2);
    if (off <= e && $urandom_range(1)) return clamp_dur(longint'(e) - off);
    return clamp_dur(longint'(e) + off);
  endfunction

  function automatic symbol_t make_symbol(int unsigned pos, logic [19:0] word, flaw_e flaw);
    symbol_t     s;
    int unsigned e0, e1, pct, slack0, slack1;
    logic        b;
    if (pos == 0) begin
      e0 = timing.hdr_mark;
      e1 = timing.hdr_space;
      pct = timing.hdr_tol;
      s.first_level  = 1'b1;
      s.second_level = 1'b0;
    end else begin
      e0 = (pos == POS_TOGGLE) ? 2 * timing.unit_dur : timing.unit_dur;
      e1 = e0;
      pct = timing.bit_tol;
      b = (pos == POS_START || pos >= FRAME_SYMBOLS) ? 1'b1 : word[FRAME_SYMBOLS - 1 - pos];
      s.first_level  = b;
      s.second_level = ~b;
    end
    slack0 = e0 * pct / 100;
    slack1 = e1 * pct / 100;
    s.first_dur  = near_dur(e0, pct);
    s.second_dur = near_dur(e1, pct);
    s.last       = 1'b0;
    // Anything past the last command bit is ignored: fill it with noise.
    if (pos >= FRAME_SYMBOLS) flaw = FLAW_NOISE;
    case (flaw)
      FLAW_LEVEL: begin
        if (pos == 0) begin
          if ($urandom_range(1)) s.first_level = 1'b0;
          else s.second_level = 1'b1;
        end else if (pos == POS_START) begin
          s.first_level = 1'b0;
        end else begin
          s.second_level = s.first_level;
        end
      end
      FLAW_FIRST_HALF:  s.first_dur  = far_dur(e0, pct);
      FLAW_SECOND_HALF: s.second_dur = far_dur(e1, pct);
      FLAW_NOISE: begin
        s.first_level  = 1'($urandom_range(1));
        s.second_level = 1'($urandom_range(1));
        s.first_dur    = DUR_W'($urandom_range(DUR_MAX));
        s.second_dur   = DUR_W'($urandom_range(DUR_MAX));
      end
      FLAW_EDGE_IN: begin
        s.first_dur  = clamp_dur(longint'(e0) + slack0);
        s.second_dur = clamp_dur(longint'(e1) - slack1);
      end
      FLAW_EDGE_OUT: begin
        s.first_dur = (e0 > slack0) ? clamp_dur(longint'(e0) - slack0 - 1)
                                    : clamp_dur(longint'(e0) + slack0 + 1);
      end
      default: ;
    endcase
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item at the falling edge, idle at random before it, and hold it
  // until the block takes it. Then advance the model and queue any result.
  task automatic send_symbol(input symbol_t s, input bit typed, input result_t typed_res);
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    first_level_i     = s.first_level;
    first_duration_i  = s.first_dur;
    second_level_i    = s.second_level;
    second_duration_i = s.second_dur;
    buffer_last_i     = s.last;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_symbol(s, r)) expected_frames.push_back(typed ? typed_res : r);
  endtask

  // Send a buffer of n symbols; the flaw lands on one position only.
  task automatic send_buffer(int unsigned n, logic [19:0] word, int unsigned flaw_pos,
                             flaw_e flaw, bit typed, logic [STATUS_W-1:0] exp_status);
    symbol_t s;
    for (int unsigned i = 0; i < n; i++) begin
      s      = make_symbol(i, word, (i == flaw_pos) ? flaw : FLAW_NONE);
      s.last = (i == n - 1);
      if (i < FRAME_SYMBOLS) symbols_decoded++;
      send_symbol(s, typed, frame_result(exp_status, word));
    end
  endtask

  // Drop valid and wait until every queued result is out, then let the
  // two-stage pipe empty of items that carry no result.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    // Mirror the write, masked to the register width.
    case (idx)
      REG_UNIT:      timing.unit_dur  = data[UNIT_W-1:0];
      REG_HDR_MARK:  timing.hdr_mark  = data[HDR_W-1:0];
      REG_HDR_SPACE: timing.hdr_space = data[HDR_W-1:0];
      REG_BIT_TOL:   timing.bit_tol   = data[PCT_W-1:0];
      REG_HDR_TOL:   timing.hdr_tol   = data[PCT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_timing(logic [CFG_DATA_W-1:0] unit_dur, logic [CFG_DATA_W-1:0] mark,
                              logic [CFG_DATA_W-1:0] space, logic [CFG_DATA_W-1:0] btol,
                              logic [CFG_DATA_W-1:0] htol);
    write_reg(REG_UNIT, unit_dur);
    write_reg(REG_HDR_MARK, mark);
    write_reg(REG_HDR_SPACE, space);
    write_reg(REG_BIT_TOL, btol);
    write_reg(REG_HDR_TOL, htol);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t: ERROR %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off counted down here.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_hold_cycles > 0) begin
      out_stall_i = 1'b1;
      stall_hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every taken result against the oldest pending frame.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no frame pending, status", status_o, 0);
      end else begin
        want = expected_frames.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (mode_bits_o !== want.mode_bits)
          report_mismatch("mode_bits", mode_bits_o, want.mode_bits);
        if (toggle_o !== want.toggle)
          report_mismatch("toggle", toggle_o, want.toggle);
        if (address_o !== want.address)
          report_mismatch("address", address_o, want.address);
        if (command_code_o !== want.command_code)
          report_mismatch("command_code", command_code_o, want.command_code);
        if (data_word_o !== want.data_word)
          report_mismatch("data_word", data_word_o, want.data_word);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    int unsigned flaw_pos;
    int unsigned pick;
    int unsigned target;
    logic [19:0] word;
    flaw_e       flaw;

    timing = '{unit_dur: UNIT_RST, hdr_mark: HDR_MARK_RST, hdr_space: HDR_SPACE_RST,
               bit_tol: BIT_TOL_RST, hdr_tol: HDR_TOL_RST};
    rearm_frame();

    // Hold reset, then release it away from the rising edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed buffers under the reset timing, no idling.
    foreach (DIRECTED_PLAN[k])
      send_buffer(DIRECTED_PLAN[k].n_symbols, DIRECTED_PLAN[k].word,
                  DIRECTED_PLAN[k].flaw_pos, DIRECTED_PLAN[k].flaw,
                  DIRECTED_PLAN[k].typed, DIRECTED_PLAN[k].exp_status);

    for (int phase = 0; phase < 8; phase++) begin
      // Registers change only with the block idle.
      wait_drained();
      case (phase)
        1: write_timing(CFG_DATA_W'(1), CFG_DATA_W'(1), CFG_DATA_W'(1),
                        CFG_DATA_W'(0), CFG_DATA_W'(0));
        2: write_timing(CFG_DATA_W'(16383), CFG_DATA_W'(32767), CFG_DATA_W'(32767),
                        CFG_DATA_W'(100), CFG_DATA_W'(100));
        3: begin
          // Unit write masks down to zero; tolerances mask to 127.
          write_timing(15'h4000, CFG_DATA_W'(0), CFG_DATA_W'(300), 15'h7FFF,
                       CFG_DATA_W'(127));
          write_reg(REG_UNUSED, 15'h1234);
        end
        4: write_timing(CFG_DATA_W'(UNIT_RST), HDR_MARK_RST, HDR_SPACE_RST,
                        CFG_DATA_W'(BIT_TOL_RST), CFG_DATA_W'(HDR_TOL_RST));
        5, 6, 7: write_timing(CFG_DATA_W'($urandom_range(16383, 1)),
                              CFG_DATA_W'($urandom_range(32767, 1)),
                              CFG_DATA_W'($urandom_range(32767, 1)),
                              CFG_DATA_W'($urandom_range(100)),
                              CFG_DATA_W'($urandom_range(100)));
        default: ;
      endcase

      @(posedge clk_i);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      // Hold the output off for a long stretch while items keep coming,
      // so the block fills up and stalls its input.
      if (phase == 4) stall_hold_cycles = 400;

      target = symbols_decoded + PHASE_ITEMS;
      while (symbols_decoded < target) begin
        pick     = $urandom_range(99);
        word     = 20'($urandom);
        flaw     = FLAW_NONE;
        flaw_pos = 0;
        n        = FRAME_SYMBOLS;
        if (pick < 55) begin
          // Well-formed frame, sometimes with an ignored tail or a wrong
          // second level on a data bit.
          if ($urandom_range(4) == 0) n = FRAME_SYMBOLS + $urandom_range(6);
          if ($urandom_range(9) == 0) begin
            flaw     = FLAW_LEVEL;
            flaw_pos = $urandom_range(FRAME_SYMBOLS - 1, 2);
          end
        end else if (pick < 78) begin
          flaw     = flaw_e'($urandom_range(FLAW_EDGE_OUT, FLAW_LEVEL));
          flaw_pos = $urandom_range(FRAME_SYMBOLS - 1);
        end else if (pick < 88) begin
          n = $urandom_range(FRAME_SYMBOLS - 1, 1);
        end else if (pick < 95) begin
          n    = $urandom_range(30, 1);
          flaw = FLAW_NOISE;
        end else begin
          n = $urandom_range(40, FRAME_SYMBOLS + 1);
        end
        send_buffer(n, word, flaw_pos, flaw, 1'b0, STATUS_OK);
        // Now and then pause the sender until every result is out.
        if ($urandom_range(19) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #4_800_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- rc6_mode0_frame_decoder_top.f -----
design/rc6d_pkg.sv
design/rc6d_cfg_regs.sv
design/rc6d_tol_chk.sv
design/rc6d_symbol_dec.sv
design/rc6_mode0_frame_decoder_top.sv
test/tb_top.sv
